// ----- sv/kct_pkg.sv -----
// Package for the keyed counter table: command, status and sequencer codes,
// plus default sizes for the table. No dependencies.
package kct_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned KeyBitsDef    = 64;
  localparam int unsigned CountBitsDef  = 32;
  localparam int unsigned MaxKDef       = 16;

  // Fixed port field widths.
  localparam int unsigned KeyW  = 64;
  localparam int unsigned CntW  = 32;
  localparam int unsigned UsedW = 7;
  localparam int unsigned WantW = 5;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned InW   = 72;
  localparam int unsigned OutW  = 112;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 3'd0,
    CMD_COUNT  = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_TOPK   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_TOPK,
    S_EMIT
  } state_e;

endpackage

// ----- sv/kct_ram.sv -----
// Single-clock table memory with one write port and one registered read port.
// No package dependencies.
module kct_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 96,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/keyed_counter_table_top_k_top.sv -----
// Top level of the keyed counter table with top-k report.
// Depends on kct_pkg and kct_ram.

// The table holds up to TABLE_DEPTH keys in insertion order, each with a
// saturating count, in one memory with a registered read. A command is taken
// only while the sequencer is idle. Insert, count, query and remove each make
// one pass over the N live entries; a remove that finds its key then moves the
// later entries down in a second pass. Top-k makes one pass per reported entry
// and loads each result into the output register. The single read port of the
// table reads one entry a cycle during a pass. A finished result sits in the
// output register, so the next command can be taken while it waits.
module keyed_counter_table_top_k_top #(
  parameter int unsigned TABLE_DEPTH = kct_pkg::TableDepthDef,
  parameter int unsigned KEY_BITS    = kct_pkg::KeyBitsDef,
  parameter int unsigned COUNT_BITS  = kct_pkg::CountBitsDef,
  parameter int unsigned MAX_K       = kct_pkg::MaxKDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // cmd[2:0], key[66:3], want_count[71:67]
  input  logic [kct_pkg::InW-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // out_key[63:0], out_count[95:64], status[97:96], entries_used[104:98]
  output logic [kct_pkg::OutW-1:0] m_axis_tdata,
  // item_valid[0]
  output logic                    m_axis_tuser,
  output logic                    m_axis_tlast
);

  import kct_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = $clog2(MAX_K + 1);
  localparam int unsigned EW = KEY_BITS + COUNT_BITS;

  state_e                state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [TW-1:0]         total_q, total_d;
  logic [TW-1:0]         iss_q, iss_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [AW-1:0]         rd_idx_q, rd_idx_d;
  logic                  hit_q, hit_d;
  logic [AW-1:0]         hit_idx_q, hit_idx_d;
  logic [COUNT_BITS-1:0] hit_cnt_q, hit_cnt_d;
  logic                  best_vld_q, best_vld_d;
  logic [AW-1:0]         best_idx_q, best_idx_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;
  logic [KEY_BITS-1:0]   best_key_q, best_key_d;
  logic                  prev_vld_q, prev_vld_d;
  logic [AW-1:0]         prev_idx_q, prev_idx_d;
  logic [COUNT_BITS-1:0] prev_cnt_q, prev_cnt_d;
  logic [KW-1:0]         k_q, k_d;
  logic [KW-1:0]         n_q, n_d;
  logic [KeyW-1:0]       res_key_q, res_key_d;
  logic [CntW-1:0]       res_cnt_q, res_cnt_d;
  status_e               res_st_q, res_st_d;
  logic                  res_vld_q, res_vld_d;
  logic                  res_last_q, res_last_d;
  logic                  m_valid_q, m_valid_d;
  logic [OutW-1:0]       m_data_q, m_data_d;
  logic                  m_user_q, m_user_d;
  logic                  m_last_q, m_last_d;

  logic                  in_acc;
  logic                  out_free;
  logic                  scan_busy;
  logic                  scan_done;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [EW-1:0]         rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [CmdW-1:0]       in_cmd;
  logic [KEY_BITS-1:0]   in_key;
  logic [WantW-1:0]      in_want;
  logic [31:0]           k_calc;
  logic                  elig;

  assign in_cmd  = s_axis_tdata[2:0];
  assign in_key  = s_axis_tdata[3 +: KEY_BITS];
  assign in_want = s_axis_tdata[71:67];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign rd_key = rd_data[KEY_BITS-1:0];
  assign rd_cnt = rd_data[EW-1:KEY_BITS];

  // A pass is issuing reads while the issue index is below the fill count.
  assign scan_busy = (state_q == S_FIND) || (state_q == S_SHIFT) || (state_q == S_TOPK);
  assign rd_en     = scan_busy && (iss_q < total_q);
  assign rd_addr   = iss_q[AW-1:0];
  assign scan_done = (iss_q >= total_q) && !rd_vld_q;

  // Top-k order: count descending, then table position ascending.
  assign elig = !prev_vld_q || (rd_cnt < prev_cnt_q) ||
                ((rd_cnt == prev_cnt_q) && (rd_idx_q > prev_idx_q));

  // Entries requested, capped by MAX_K and the live count.
  always_comb begin
    k_calc = 32'(in_want);
    if (k_calc > MAX_K) begin
      k_calc = MAX_K;
    end
    if (k_calc > 32'(total_q)) begin
      k_calc = 32'(total_q);
    end
  end

  kct_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_cmd == CMD_TOPK) begin
            state_d = (k_calc == 32'd0) ? S_EMIT : S_TOPK;
          end else if (in_cmd == CMD_INSERT || in_cmd == CMD_COUNT ||
                       in_cmd == CMD_QUERY || in_cmd == CMD_REMOVE) begin
            state_d = S_FIND;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_FIND: begin
        if (scan_done) begin
          state_d = (cmd_q == CMD_REMOVE && hit_q) ? S_SHIFT : S_EMIT;
        end
      end
      S_SHIFT, S_TOPK: begin
        if (scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = (cmd_q == CMD_TOPK && !res_last_q) ? S_TOPK : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cmd_d      = cmd_q;
    key_d      = key_q;
    total_d    = total_q;
    iss_d      = iss_q;
    rd_vld_d   = rd_en;
    rd_idx_d   = rd_addr;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_cnt_d  = hit_cnt_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    best_key_d = best_key_q;
    prev_vld_d = prev_vld_q;
    prev_idx_d = prev_idx_q;
    prev_cnt_d = prev_cnt_q;
    k_d        = k_q;
    n_d        = n_q;
    res_key_d  = res_key_q;
    res_cnt_d  = res_cnt_q;
    res_st_d   = res_st_q;
    res_vld_d  = res_vld_q;
    res_last_d = res_last_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    m_last_d   = m_last_q;
    wr_en      = 1'b0;
    wr_addr    = rd_idx_q;
    wr_data    = rd_data;

    if (rd_en) begin
      iss_d = iss_q + 1'b1;
    end
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d      = cmd_e'(in_cmd);
          key_d      = in_key;
          iss_d      = '0;
          hit_d      = 1'b0;
          best_vld_d = 1'b0;
          prev_vld_d = 1'b0;
          n_d        = '0;
          k_d        = KW'(k_calc);
          res_key_d  = KeyW'(in_key);
          res_cnt_d  = '0;
          res_st_d   = ST_OK;
          res_vld_d  = 1'b0;
          res_last_d = 1'b1;
          if (in_cmd == CMD_TOPK) begin
            res_key_d = '0;
          end
        end
      end
      S_FIND: begin
        // Compare the returned entry against the command key.
        if (rd_vld_q && !hit_q && rd_key == key_q) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
          hit_cnt_d = rd_cnt;
        end
        if (scan_done) begin
          unique case (cmd_q)
            CMD_INSERT: begin
              priority if (hit_q) begin
                res_cnt_d = CntW'(hit_cnt_q);
                res_st_d  = ST_DUPLICATE;
                res_vld_d = 1'b1;
              end else if (total_q >= TW'(TABLE_DEPTH)) begin
                res_st_d = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = total_q[AW-1:0];
                wr_data   = {{COUNT_BITS{1'b0}}, key_q};
                total_d   = total_q + 1'b1;
                res_vld_d = 1'b1;
              end
            end
            CMD_COUNT, CMD_QUERY: begin
              if (hit_q) begin
                res_vld_d = 1'b1;
                res_cnt_d = CntW'(hit_cnt_q);
                if (cmd_q == CMD_COUNT && !(&hit_cnt_q)) begin
                  wr_en     = 1'b1;
                  wr_addr   = hit_idx_q;
                  wr_data   = {hit_cnt_q + 1'b1, key_q};
                  res_cnt_d = CntW'(hit_cnt_q + 1'b1);
                end
              end else begin
                res_st_d = ST_NOT_FOUND;
              end
            end
            CMD_REMOVE: begin
              if (hit_q) begin
                res_vld_d = 1'b1;
                res_cnt_d = CntW'(hit_cnt_q);
                iss_d     = TW'(hit_idx_q) + 1'b1;
              end else begin
                res_st_d = ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        // Move each later entry down by one place.
        if (rd_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_q - 1'b1;
        end
        if (scan_done) begin
          total_d = total_q - 1'b1;
        end
      end
      S_TOPK: begin
        if (rd_vld_q && elig && (!best_vld_q || rd_cnt > best_cnt_q)) begin
          best_vld_d = 1'b1;
          best_idx_d = rd_idx_q;
          best_cnt_d = rd_cnt;
          best_key_d = rd_key;
        end
        if (scan_done) begin
          res_key_d  = KeyW'(best_key_q);
          res_cnt_d  = CntW'(best_cnt_q);
          res_st_d   = ST_OK;
          res_vld_d  = 1'b1;
          res_last_d = (KW'(n_q + 1'b1) == k_q);
          prev_vld_d = 1'b1;
          prev_idx_d = best_idx_q;
          prev_cnt_d = best_cnt_q;
          n_d        = n_q + 1'b1;
        end
      end
      S_EMIT: begin
        // Load the output register and prepare the next top-k pass.
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_data_d   = {7'd0, UsedW'(total_q), res_st_q, res_cnt_q, res_key_q};
          m_user_d   = res_vld_q;
          m_last_d   = res_last_q;
          iss_d      = '0;
          best_vld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    rd_idx_q   <= rd_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_cnt_q  <= hit_cnt_d;
    best_vld_q <= best_vld_d;
    best_idx_q <= best_idx_d;
    best_cnt_q <= best_cnt_d;
    best_key_q <= best_key_d;
    prev_vld_q <= prev_vld_d;
    prev_idx_q <= prev_idx_d;
    prev_cnt_q <= prev_cnt_d;
    k_q        <= k_d;
    n_q        <= n_d;
    res_key_q  <= res_key_d;
    res_cnt_q  <= res_cnt_d;
    res_st_q   <= res_st_d;
    res_vld_q  <= res_vld_d;
    res_last_q <= res_last_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
  // The fill count never passes the table depth.
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // The fill count never rises by more than one per cycle.
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q > $past(total_q)) |-> (total_q == $past(total_q) + 1'b1))
    else $error("fill count jumped");

  // A transaction without an entry always closes its command.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |-> m_last_q)
    else $error("empty result not marked last");
`endif

endmodule

// ----- sim/keyed_counter_table_top_k_top_test.sv -----
// Testbench for keyed_counter_table_top_k_top: drives commands on the input stream,
// predicts each result from its own copy of the table and compares every result.
// Depends on kct_pkg and the block's RTL.
module keyed_counter_table_top_k_top_test;
  import kct_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned TopMax = 16;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] cnt;
    logic [1:0]  status;
    logic [6:0]  used;
    logic        valid;
    logic        last;
  } table_result_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  // Predicted table contents, in insertion order.
  logic [63:0] tbl_key [Depth];
  logic [31:0] tbl_cnt [Depth];
  int unsigned tbl_used;

  table_result_t pending_results[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  logic [63:0] known_keys[$];

  keyed_counter_table_top_k_top u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic table_result_t make_result(logic [63:0] key, logic [31:0] cnt,
                                                status_e st, logic valid, logic last);
    table_result_t r;
    r.key = key;
    r.cnt = cnt;
    r.status = st;
    r.used = tbl_used[6:0];
    r.valid = valid;
    r.last = last;
    return r;
  endfunction

  // Append one predicted result to the queue of expected transactions.
  function automatic void add_expected(table_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Update the predicted table for one command and queue its results.
  task automatic predict_command(logic [2:0] cmd, logic [63:0] key, logic [4:0] want);
    int idx;
    int unsigned k;
    int best;
    logic [31:0] old_cnt;
    bit taken [Depth];
    idx = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (idx < 0 && tbl_key[i] == key) idx = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (idx >= 0) begin
          add_expected(make_result(key, tbl_cnt[idx], ST_DUPLICATE, 1'b1, 1'b1));
        end else if (tbl_used >= Depth) begin
          add_expected(make_result(key, '0, ST_FULL, 1'b0, 1'b1));
        end else begin
          tbl_key[tbl_used] = key;
          tbl_cnt[tbl_used] = '0;
          tbl_used++;
          add_expected(make_result(key, '0, ST_OK, 1'b1, 1'b1));
        end
      end
      CMD_COUNT, CMD_QUERY: begin
        if (idx < 0) begin
          add_expected(make_result(key, '0, ST_NOT_FOUND, 1'b0, 1'b1));
        end else begin
          if (cmd == CMD_COUNT && tbl_cnt[idx] != '1) tbl_cnt[idx]++;
          add_expected(make_result(key, tbl_cnt[idx], ST_OK, 1'b1, 1'b1));
        end
      end
      CMD_REMOVE: begin
        if (idx < 0) begin
          add_expected(make_result(key, '0, ST_NOT_FOUND, 1'b0, 1'b1));
        end else begin
          old_cnt = tbl_cnt[idx];
          for (int i = idx; i + 1 < tbl_used; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_cnt[i] = tbl_cnt[i+1];
          end
          tbl_used--;
          add_expected(make_result(key, old_cnt, ST_OK, 1'b1, 1'b1));
        end
      end
      CMD_TOPK: begin
        k = want;
        if (k > TopMax) k = TopMax;
        if (k > tbl_used) k = tbl_used;
        if (k == 0) begin
          add_expected(make_result('0, '0, ST_OK, 1'b0, 1'b1));
        end else begin
          for (int i = 0; i < Depth; i++) taken[i] = 1'b0;
          // Selection by strictly greater count keeps ties in insertion order.
          for (int n = 0; n < k; n++) begin
            best = -1;
            for (int i = 0; i < tbl_used; i++) begin
              if (!taken[i] && (best < 0 || tbl_cnt[i] > tbl_cnt[best])) best = i;
            end
            taken[best] = 1'b1;
            add_expected(make_result(tbl_key[best], tbl_cnt[best], ST_OK,
                                     1'b1, n + 1 == k));
          end
        end
      end
      default: begin
        add_expected(make_result(key, '0, ST_OK, 1'b0, 1'b1));
      end
    endcase
  endtask

  // Send one command transaction after a random gap. The valid stays high
  // across a zero gap, so back-to-back transactions see one assignment per edge.
  task automatic send_command(logic [2:0] cmd, logic [63:0] key, logic [4:0] want);
    int unsigned gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {want, key, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_command(cmd, key, want);
  endtask

  function automatic logic [63:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  // Pick a key that was used before most of the time, so lookups hit.
  function automatic logic [63:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(0, 4) != 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    return random_key();
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_basics();
    send_command(CMD_TOPK, '0, 5'd16);
    send_command(CMD_QUERY, 64'h0, 5'd0);
    send_command(CMD_INSERT, 64'h0, 5'd0);
    send_command(CMD_INSERT, '1, 5'd31);
    send_command(CMD_INSERT, 64'h0, 5'd0);
    send_command(CMD_COUNT, '1, 5'd0);
    send_command(CMD_COUNT, '1, 5'd0);
    send_command(CMD_COUNT, 64'h0, 5'd0);
    send_command(CMD_QUERY, '1, 5'd0);
    send_command(CMD_COUNT, 64'h5555_AAAA_5555_AAAA, 5'd0);
    send_command(CMD_INSERT, 64'hA5A5_0000_FFFF_1234, 5'd0);
    send_command(CMD_COUNT, 64'hA5A5_0000_FFFF_1234, 5'd0);
    send_command(CMD_TOPK, '0, 5'd0);
    send_command(CMD_TOPK, '0, 5'd1);
    send_command(CMD_TOPK, '0, 5'd3);
    send_command(CMD_TOPK, '1, 5'd31);
    send_command(3'd5, '1, 5'd31);
    send_command(3'd6, 64'h1, 5'd1);
    send_command(3'd7, '0, 5'd0);
    send_command(CMD_REMOVE, 64'h0, 5'd0);
    send_command(CMD_REMOVE, 64'h0, 5'd0);
    send_command(CMD_TOPK, '0, 5'd16);
    send_command(CMD_REMOVE, '1, 5'd0);
    send_command(CMD_REMOVE, 64'hA5A5_0000_FFFF_1234, 5'd0);
    send_command(CMD_TOPK, '0, 5'd2);
  endtask

  // Fill the table to its depth, insert into the full table, then ask for a top-k report.
  task automatic test_full_table();
    logic [63:0] key;
    for (int i = 0; i < Depth; i++) begin
      key = random_key();
      known_keys = {known_keys, key};
      send_command(CMD_INSERT, key, 5'd0);
    end
    send_command(CMD_INSERT, random_key(), 5'd0);
    send_command(CMD_INSERT, known_keys[3], 5'd0);
    send_command(CMD_TOPK, '0, 5'd20);
  endtask

  // Random mix led by counts of known keys, with queries, removes, inserts, top-k reports and undefined commands.
  task automatic test_random_mix(int unsigned items);
    int unsigned sel;
    logic [63:0] key;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(0, 99);
      key = pick_key();
      if (sel < 40) send_command(CMD_COUNT, key, 5'($urandom()));
      else if (sel < 50) send_command(CMD_QUERY, key, 5'($urandom()));
      else if (sel < 60) send_command(CMD_REMOVE, key, 5'($urandom()));
      else if (sel < 75) begin
        if ($urandom_range(0, 1) == 0) begin
          key = random_key();
          known_keys = {known_keys, key};
        end
        send_command(CMD_INSERT, key, 5'($urandom()));
      end else if (sel < 95) begin
        send_command(CMD_TOPK, random_key(), 5'($urandom_range(0, 5) == 0 ?
                                                $urandom_range(16, 31) : $urandom_range(0, 4)));
      end else begin
        send_command(3'($urandom_range(5, 7)), random_key(), 5'($urandom()));
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    tbl_used = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    test_full_table();
    test_random_mix(190);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (4 * Depth) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Output stall pattern: short random stalls with occasional long ones.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 49) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Check each accepted result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    table_result_t got;
    table_result_t want_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.key = m_axis_tdata[63:0];
      got.cnt = m_axis_tdata[95:64];
      got.status = m_axis_tdata[97:96];
      got.used = m_axis_tdata[104:98];
      got.valid = m_axis_tuser;
      got.last = m_axis_tlast;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result transaction: %p", got);
      end else begin
        want_res = pending_results.pop_front();
        if (got !== want_res) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Mismatch: expected %p, got %p", want_res, got);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    idle_cycles = 0;
  end

endmodule
